>>> hw/rtl/jtag_scan_sequencer_assert.svh
// Assertion macros for the scan sequencer checkers.
`ifndef JTAG_SCAN_SEQUENCER_ASSERT_SVH
`define JTAG_SCAN_SEQUENCER_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define JSS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define JSS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> hw/rtl/jss_pkg.sv
// Shared types, constants and lookup functions for the JTAG scan sequencer.
package jss_pkg;

  localparam int DATA_W        = 32;
  localparam int KIND_W        = 3;
  localparam int NBITS_W       = 6;
  localparam int STEP_W        = 3;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [STEP_W-1:0] RESET_HIGH_STEPS = STEP_W'(5);
  localparam logic [STEP_W-1:0] RESET_LAST_STEP  = STEP_W'(5);
  localparam logic [STEP_W-1:0] TAIL_LAST_STEP   = STEP_W'(1);

  localparam logic [KIND_W-1:0] KIND_RESET    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_IR_IDLE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DR       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IR_PAUSE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DR_PAUSE = 3'd4;

  typedef enum logic [1:0] {
    CLS_RESET,
    CLS_SCAN,
    CLS_BAD
  } cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_DATA,
    ST_TAIL,
    ST_RST,
    ST_BAD
  } state_t;

  typedef struct packed {
    logic   load;
    logic   emit;
    logic   mark_last;
    state_t phase;
  } cmd_t;

  typedef struct packed {
    cls_t in_cls;
    logic in_first;
    logic in_last;
    logic in_has_bits;
    logic has_bits;
    logic last;
    logic phase_end;
    logic out_free;
  } sts_t;

  function automatic cls_t kind_class(input logic [KIND_W-1:0] kind);
    cls_t c;
    if (kind == KIND_RESET) begin
      c = CLS_RESET;
    end else if (kind > KIND_DR_PAUSE) begin
      c = CLS_BAD;
    end else begin
      c = CLS_SCAN;
    end
    return c;
  endfunction

  // Index of the final header step for a scan kind.
  function automatic logic [STEP_W-1:0] hdr_last_step(input logic [KIND_W-1:0] kind);
    return (kind == KIND_DR) ? STEP_W'(3) : STEP_W'(4);
  endfunction

  // TMS level of one header step.
  function automatic logic hdr_tms(input logic [KIND_W-1:0] kind,
                                   input logic [STEP_W-1:0] step);
    logic [4:0] seq;
    logic       t;
    unique case (kind)
      KIND_DR:       seq = 5'b00010;
      KIND_DR_PAUSE: seq = 5'b00111;
      default:       seq = 5'b00110;
    endcase
    unique case (step)
      3'd0:    t = seq[0];
      3'd1:    t = seq[1];
      3'd2:    t = seq[2];
      3'd3:    t = seq[3];
      3'd4:    t = seq[4];
      default: t = 1'b0;
    endcase
    return t;
  endfunction

endpackage

>>> hw/rtl/jss_ctrl.sv
// Sequencer controller: walks header, data, tail, reset and bad-kind phases.
module jss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  jss_pkg::sts_t sts,
  output jss_pkg::cmd_t cmd
);
  import jss_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (sts.in_cls)
            CLS_RESET: state_next = ST_RST;
            CLS_BAD:   state_next = ST_BAD;
            default: begin
              if (sts.in_first) begin
                state_next = ST_HDR;
              end else if (sts.in_has_bits) begin
                state_next = ST_DATA;
              end else if (sts.in_last) begin
                state_next = ST_TAIL;
              end else begin
                state_next = ST_IDLE;
              end
            end
          endcase
        end
      end
      ST_HDR: begin
        if (sts.out_free && sts.phase_end) begin
          if (sts.has_bits) begin
            state_next = ST_DATA;
          end else if (sts.last) begin
            state_next = ST_TAIL;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        if (sts.out_free && sts.phase_end) begin
          state_next = sts.last ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL, ST_RST, ST_BAD: begin
        if (sts.out_free && sts.phase_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd.load      = (state == ST_IDLE) && in_valid;
    cmd.emit      = (state != ST_IDLE) && sts.out_free;
    cmd.mark_last = cmd.emit && sts.phase_end && (state_next == ST_IDLE);
    cmd.phase     = state;
  end

endmodule

>>> hw/rtl/jss_dp.sv
// Sequencer datapath: word shift register, step counters and output register.
module jss_dp #(
  parameter int WORD_BITS = jss_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [jss_pkg::KIND_W-1:0]   scan_kind,
  input  logic [jss_pkg::DATA_W-1:0]   data_word,
  input  logic [jss_pkg::NBITS_W-1:0]  bits_in_word,
  input  logic                         first_of_scan,
  input  logic                         last_of_scan,
  input  jss_pkg::cmd_t                cmd,
  output jss_pkg::sts_t                sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         tms,
  output logic                         tdi,
  output logic                         bad_kind,
  output logic                         last_in_run
);
  import jss_pkg::*;

  localparam int CNT_W = $clog2(WORD_BITS + 1);

  logic [KIND_W-1:0]    kind;
  logic                 last_flag;
  logic [WORD_BITS-1:0] shreg;
  logic [CNT_W-1:0]     remaining;
  logic [STEP_W-1:0]    step;
  logic [CNT_W-1:0]     nbits_sat;
  logic                 phase_end;
  logic                 step_tms;
  logic                 step_tdi;
  logic                 step_bad;

  assign nbits_sat = (bits_in_word > NBITS_W'(WORD_BITS)) ? CNT_W'(WORD_BITS)
                                                          : bits_in_word[CNT_W-1:0];

  always_comb begin
    phase_end = 1'b0;
    step_tms  = 1'b0;
    step_tdi  = 1'b0;
    step_bad  = 1'b0;
    unique case (cmd.phase)
      ST_HDR: begin
        phase_end = (step == hdr_last_step(kind));
        step_tms  = hdr_tms(kind, step);
      end
      ST_DATA: begin
        phase_end = (remaining == CNT_W'(1));
        step_tms  = last_flag && phase_end;
        step_tdi  = shreg[0];
      end
      ST_TAIL: begin
        phase_end = (step == TAIL_LAST_STEP);
        step_tms  = (kind != KIND_IR_PAUSE) && (step == '0);
      end
      ST_RST: begin
        phase_end = (step == RESET_LAST_STEP);
        step_tms  = (step < RESET_HIGH_STEPS);
      end
      ST_BAD: begin
        phase_end = 1'b1;
        step_bad  = 1'b1;
      end
      default: phase_end = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind      <= scan_kind;
      last_flag <= last_of_scan;
      shreg     <= data_word[WORD_BITS-1:0];
      remaining <= nbits_sat;
      step      <= '0;
    end else if (cmd.emit) begin
      step <= phase_end ? '0 : step + STEP_W'(1);
      if (cmd.phase == ST_DATA) begin
        shreg     <= shreg >> 1;
        remaining <= remaining - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tms         <= step_tms;
      tdi         <= step_tdi;
      bad_kind    <= step_bad;
      last_in_run <= cmd.mark_last;
    end
  end

  always_comb begin
    sts.in_cls      = kind_class(scan_kind);
    sts.in_first    = first_of_scan;
    sts.in_last     = last_of_scan;
    sts.in_has_bits = (bits_in_word != '0);
    sts.has_bits    = (remaining != '0);
    sts.last        = last_flag;
    sts.phase_end   = phase_end;
    sts.out_free    = !out_valid || out_ready;
  end

endmodule

>>> hw/rtl/jtag_scan_sequencer.sv
// A word is loaded in idle; its first pin step passes the state register, then the output
// register once that is free. One pin step per cycle while out_ready is high, a rate set by
// the single output register and the one-step-per-cycle controller. Steps per word: header
// (0, 4 or 5) + data bits + tail (0 or 2), 6 for a TAP reset, 1 for a bad kind.
// Reset: synchronous, clears the controller state and the output valid; no clearing pass.
module jtag_scan_sequencer #(
  parameter int WORD_BITS = jss_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [jss_pkg::KIND_W-1:0]   scan_kind,
  input  logic [jss_pkg::DATA_W-1:0]   data_word,
  input  logic [jss_pkg::NBITS_W-1:0]  bits_in_word,
  input  logic                         first_of_scan,
  input  logic                         last_of_scan,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         tms,
  output logic                         tdi,
  output logic                         bad_kind,
  output logic                         last_in_run
);
  import jss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  jss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jss_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .scan_kind     (scan_kind),
    .data_word     (data_word),
    .bits_in_word  (bits_in_word),
    .first_of_scan (first_of_scan),
    .last_of_scan  (last_of_scan),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tms           (tms),
    .tdi           (tdi),
    .bad_kind      (bad_kind),
    .last_in_run   (last_in_run)
  );

endmodule

>>> hw/rtl/jss_checker.sv
// Port-level checker for the JTAG scan sequencer, bound to the top level.
`include "jtag_scan_sequencer_assert.svh"

module jss_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [jss_pkg::KIND_W-1:0]  scan_kind,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        tms,
  input logic                        tdi,
  input logic                        bad_kind,
  input logic                        last_in_run
);
  import jss_pkg::*;

  `JSS_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid, "output valid after reset")
  `JSS_ASSERT(a_bad_word, clk, rst, out_valid && bad_kind |-> !tms && !tdi && last_in_run, "bad kind word malformed")
  `JSS_ASSERT(a_reset_busy, clk, rst, in_valid && in_ready && scan_kind == KIND_RESET |=> !in_ready, "ready during TAP reset run")
  `JSS_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(tms) && $stable(tdi) && $stable(last_in_run), "stalled word changed")

endmodule

bind jtag_scan_sequencer jss_checker u_jss_checker (.*);
